### rtl/core/sldec_pkg.sv
`timescale 1ns / 1ps

package sldec_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd2;
    localparam logic [1:0] CFG_RESPONSE_MASK = 2'd3;

    localparam logic [7:0] RST_SYNC_FIRST    = 8'd0;
    localparam logic [7:0] RST_SYNC_SECOND   = 8'd0;
    localparam logic [7:0] RST_PAYLOAD_LIMIT = 8'd255;
    localparam logic [7:0] RST_RESPONSE_MASK = 8'd128;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_CMD     = 7'b0000010,
        PH_SEQ     = 7'b0000100,
        PH_LEN     = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CRC_LO  = 7'b0100000,
        PH_CRC_HI  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] payload_limit;
        logic [7:0] response_mask;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data_byte;
        logic       frame_status;
        logic [7:0] command_code;
        logic       resp_flag;
        logic [7:0] sequence_res;
        logic [7:0] payload_length;
    } res_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/sldec_parser.sv
`timescale 1ns / 1ps

module sldec_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  sldec_pkg::cfg_t     cfg,
    output sldec_pkg::res_t     res
);

    sldec_pkg::phase_t phase_reg, phase_next;
    logic              saw_first_reg, saw_first_next;
    logic [7:0]        command_reg, command_next;
    logic [7:0]        sequence_reg, sequence_next;
    logic [7:0]        length_reg, length_next;
    logic [7:0]        left_reg, left_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;

    logic [15:0]       crc_upd;
    logic [7:0]        left_dec;

    assign crc_upd  = sldec_pkg::crc_byte(crc_reg, rx_byte);
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        saw_first_next = saw_first_reg;
        command_next   = command_reg;
        sequence_next  = sequence_reg;
        length_next    = length_reg;
        left_next      = left_reg;
        crc_next       = crc_reg;
        crc_lo_next    = crc_lo_reg;
        res            = '0;

        if (step)
        begin
            unique case (phase_reg)
                sldec_pkg::PH_CMD:
                begin
                    command_next = rx_byte;
                    crc_next     = sldec_pkg::crc_byte(sldec_pkg::CRC_INIT, rx_byte);
                    phase_next   = sldec_pkg::PH_SEQ;
                end
                sldec_pkg::PH_SEQ:
                begin
                    sequence_next = rx_byte;
                    crc_next      = crc_upd;
                    phase_next    = sldec_pkg::PH_LEN;
                end
                sldec_pkg::PH_LEN:
                begin
                    length_next = rx_byte;
                    crc_next    = crc_upd;
                    if (rx_byte > cfg.payload_limit)
                    begin
                        res.valid          = 1'b1;
                        res.kind           = sldec_pkg::KIND_REPORT;
                        res.frame_status   = sldec_pkg::STATUS_BAD;
                        res.command_code   = command_reg & ~cfg.response_mask;
                        res.resp_flag      = |(command_reg & cfg.response_mask);
                        res.sequence_res   = sequence_reg;
                        res.payload_length = rx_byte;
                        phase_next         = sldec_pkg::PH_HUNT;
                        saw_first_next     = 1'b0;
                    end
                    else
                    begin
                        left_next  = rx_byte;
                        phase_next = (rx_byte == 8'd0) ? sldec_pkg::PH_CRC_LO
                                                       : sldec_pkg::PH_PAYLOAD;
                    end
                end
                sldec_pkg::PH_PAYLOAD:
                begin
                    crc_next      = crc_upd;
                    left_next     = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = sldec_pkg::PH_CRC_LO;
                    end
                    res.valid     = 1'b1;
                    res.kind      = sldec_pkg::KIND_PAYLOAD;
                    res.data_byte = rx_byte;
                end
                sldec_pkg::PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = sldec_pkg::PH_CRC_HI;
                end
                sldec_pkg::PH_CRC_HI:
                begin
                    res.valid          = 1'b1;
                    res.kind           = sldec_pkg::KIND_REPORT;
                    res.frame_status   = ({rx_byte, crc_lo_reg} == crc_reg)
                                         ? sldec_pkg::STATUS_OK : sldec_pkg::STATUS_BAD;
                    res.command_code   = command_reg & ~cfg.response_mask;
                    res.resp_flag      = |(command_reg & cfg.response_mask);
                    res.sequence_res   = sequence_reg;
                    res.payload_length = length_reg;
                    phase_next         = sldec_pkg::PH_HUNT;
                    saw_first_next     = 1'b0;
                end
                default:
                begin
                    // hunting; unknown codes land here too
                    phase_next = sldec_pkg::PH_HUNT;
                    if (saw_first_reg && (rx_byte == cfg.sync_second))
                    begin
                        saw_first_next = 1'b0;
                        phase_next     = sldec_pkg::PH_CMD;
                    end
                    else
                    begin
                        saw_first_next = (rx_byte == cfg.sync_first);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sldec_pkg::PH_HUNT;
            saw_first_reg <= 1'b0;
            command_reg   <= 8'd0;
            sequence_reg  <= 8'd0;
            length_reg    <= 8'd0;
            left_reg      <= 8'd0;
            crc_reg       <= sldec_pkg::CRC_INIT;
            crc_lo_reg    <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            saw_first_reg <= saw_first_next;
            command_reg   <= command_next;
            sequence_reg  <= sequence_next;
            length_reg    <= length_next;
            left_reg      <= left_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
        end
    end

endmodule

### rtl/core/sync_length_crc16_frame_decoder.sv
`timescale 1ns / 1ps

// Framed byte-stream decoder: hunts for the sync pair, reads command,
// sequence and length, passes each payload byte out as it arrives and checks
// a little-endian CRC-16/CCITT-FALSE over command through payload, ending
// each frame with one report transfer (status, command without response bits,
// response flag, sequence, length). An overlong length ends the frame as bad
// at once. One byte is taken per cycle when in_stall is low: the byte sits in
// an input register, the parser and byte-wide CRC update work on it
// combinationally, and the result goes to an output register. A stalled
// result holds the input register, which then stalls the input. The user must
// write configuration only while the decoder is idle; it is not enforced here.
module sync_length_crc16_frame_decoder
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic       frame_status,
    output logic [7:0] command_code,
    output logic       resp_flag,
    output logic [7:0] sequence_res,
    output logic [7:0] payload_length
);

    sldec_pkg::cfg_t cfg_reg;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    sldec_pkg::res_t out_reg;
    sldec_pkg::res_t res;
    logic            advance;
    logic            step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= sldec_pkg::RST_SYNC_FIRST;
            cfg_reg.sync_second   <= sldec_pkg::RST_SYNC_SECOND;
            cfg_reg.payload_limit <= sldec_pkg::RST_PAYLOAD_LIMIT;
            cfg_reg.response_mask <= sldec_pkg::RST_RESPONSE_MASK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sldec_pkg::CFG_SYNC_FIRST:    cfg_reg.sync_first    <= cfg_data;
                sldec_pkg::CFG_SYNC_SECOND:   cfg_reg.sync_second   <= cfg_data;
                sldec_pkg::CFG_PAYLOAD_LIMIT: cfg_reg.payload_limit <= cfg_data;
                sldec_pkg::CFG_RESPONSE_MASK: cfg_reg.response_mask <= cfg_data;
                default: ;
            endcase
        end
    end

    // output register free or being emptied this cycle
    assign advance  = !out_reg.valid || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sldec_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // res is all zero when no result is produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_reg.valid;
    assign kind           = out_reg.kind;
    assign data_byte      = out_reg.data_byte;
    assign frame_status   = out_reg.frame_status;
    assign command_code   = out_reg.command_code;
    assign resp_flag      = out_reg.resp_flag;
    assign sequence_res   = out_reg.sequence_res;
    assign payload_length = out_reg.payload_length;

endmodule
